FILE: hw/rtl/pic_pkg.sv
// Shared widths, register codes, reset values and unit request types for the PID axis.
package pic_pkg;

    // Datapath widths
    localparam int FIELD_W = 24;    // target, measure
    localparam int DT_W    = 16;    // step time
    localparam int GAIN_W  = 16;    // Q8.8 gains
    localparam int LIM_W   = 23;    // integral bound
    localparam int CFG_W   = 23;    // widest register
    localparam int CFG_IDX_W = 2;
    localparam int ERR_W   = 25;
    localparam int DIFF_W  = 26;
    localparam int INTEG_W = 24;
    localparam int DRIVE_W = 32;

    // Serial multiplier: signed multiplicand times unsigned 16-bit digit string
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Serial divider: dividend is |diff| << 16
    localparam int DIV_N_W = DIFF_W + DT_W;
    localparam int DIV_D_W = DT_W;

    // Drive accumulator: three products plus growth
    localparam int SUM_W = MUL_P_W + 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 2'd3;

    // Register reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_PROP   = 16'd166;
    localparam logic [GAIN_W-1:0] RST_GAIN_INTEG  = 16'd5;
    localparam logic [GAIN_W-1:0] RST_GAIN_DERIV  = 16'd46;
    localparam logic [LIM_W-1:0]  RST_INTEG_LIMIT = 23'd64000;

    // Multiply request
    typedef struct packed {
        logic                      go;
        logic signed [MUL_A_W-1:0] a;
        logic        [MUL_B_W-1:0] b;
    } t_mul_req;

    // Divide request
    typedef struct packed {
        logic               go;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
        logic               neg;
    } t_div_req;

endpackage

FILE: hw/rtl/pic_mul_serial.sv
// Shift-add multiplier: one multiplier bit per cycle, signed times unsigned.
module pic_mul_serial
    import pic_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mul_req                  i_req,
    output logic                      o_done,
    output logic signed [MUL_P_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(MUL_B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

    logic signed [MUL_A_W:0]   r_hi;
    logic        [MUL_B_W-1:0] r_lo;
    logic        [MUL_B_W-1:0] r_b;
    logic signed [MUL_A_W-1:0] r_a;
    logic        [CNT_W-1:0]   r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic signed [MUL_A_W:0]   w_sum;

    // partial sum for the current multiplier bit
    assign w_sum = r_hi + (r_b[0] ? {r_a[MUL_A_W-1], r_a} : '0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shifts right as bits are retired
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_hi <= '0;
            r_lo <= '0;
            r_a  <= i_req.a;
            r_b  <= i_req.b;
        end else if (r_busy) begin
            r_hi <= {w_sum[MUL_A_W], w_sum[MUL_A_W:1]};
            r_lo <= {w_sum[0], r_lo[MUL_B_W-1:1]};
            r_b  <= {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[MUL_A_W-1:0], r_lo};

endmodule

FILE: hw/rtl/pic_div_serial.sv
// Restoring divider: one quotient bit per cycle, sign applied and saturated to 32 bits.
module pic_div_serial
    import pic_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_div_req                  i_req,
    output logic                      o_done,
    output logic signed [DRIVE_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_N_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N_W - 1);
    localparam logic [DIV_N_W-1:0] POS_MAX = DIV_N_W'(64'h7FFF_FFFF);
    localparam logic [DIV_N_W-1:0] NEG_MAX = DIV_N_W'(64'h8000_0000);

    logic [DIV_N_W-1:0] r_num;   // dividend in, quotient out
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_D_W:0]   w_trial;
    logic [DIV_D_W:0]   w_diff;
    logic               w_fits;

    // trial subtract of the divisor
    assign w_trial = {r_rem, r_num[DIV_N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fits  = !w_diff[DIV_D_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
            r_num <= {r_num[DIV_N_W-2:0], w_fits};
        end
    end

    // sign and saturation of the finished quotient
    always_comb begin
        if (r_neg) begin
            o_quot = (r_num > NEG_MAX) ? 32'sh8000_0000 : -$signed(r_num[DRIVE_W-1:0]);
        end else begin
            o_quot = (r_num > POS_MAX) ? 32'sh7FFF_FFFF : $signed(r_num[DRIVE_W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule

FILE: hw/rtl/pid_integral_clamp.sv
// PID axis top level: sequencer, state, configuration and output register.
//
//  channel | direction | handshake                  | word
//  in      | input     | i_in_valid / o_in_stall    | i_target, i_measure, i_step_time
//  out     | output    | o_out_valid / i_out_stall  | o_drive
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A nonzero step time word makes four passes (request, load, 16 shifts, done) of the shared
// shift-add multiplier; the 42-step divider overlaps the first three and is awaited before
// the last; the final state then loads the output register. A zero step time word goes from
// idle straight to the final state. One word is in work at a time, so the next is taken once
// the sequencer is back in idle; a stalled output holds the sequencer in its last state.
// Reset is synchronous: default registers, zero integral/error.
module pid_integral_clamp
    import pic_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [FIELD_W-1:0]   i_target,
    input  logic signed [FIELD_W-1:0]   i_measure,
    input  logic        [DT_W-1:0]      i_step_time,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [DRIVE_W-1:0]   o_drive,
    input  logic                        i_cfg_we,
    input  logic        [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MI   = 7'b0000010,
        S_MP   = 7'b0000100,
        S_MA   = 7'b0001000,
        S_WD   = 7'b0010000,
        S_MD   = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    localparam logic signed [DRIVE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DRIVE_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam int SHR_W = SUM_W - 8;

    t_state r_state, n_state;

    logic [GAIN_W-1:0] r_gain_prop, r_gain_integ, r_gain_deriv;
    logic [LIM_W-1:0]  r_integ_limit;

    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [ERR_W-1:0]   r_prev, n_prev;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic signed [DRIVE_W-1:0] r_deriv;
    logic                      r_ddone, n_ddone;
    logic                      r_out_vld, n_out_vld;
    logic signed [DRIVE_W-1:0] r_out, n_out;
    t_mul_req                  r_mreq, n_mreq;
    t_div_req                  r_dreq, n_dreq;

    logic                      w_mul_done;
    logic signed [MUL_P_W-1:0] w_prod;
    logic                      w_div_done;
    logic signed [DRIVE_W-1:0] w_quot;

    logic                      w_in_acc;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [DIFF_W-1:0]  w_diff;
    logic        [DIFF_W-1:0]  w_mag;
    logic signed [DIFF_W-1:0]  w_acc;
    logic signed [DIFF_W-1:0]  w_lim;
    logic signed [INTEG_W-1:0] w_clamped;
    logic signed [SUM_W-1:0]   w_prod_ext;
    logic signed [SHR_W-1:0]   w_shr;
    logic signed [DRIVE_W-1:0] w_drive;

    pic_mul_serial u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pic_div_serial u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // input side
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // error and error change
    assign w_err  = {i_target[FIELD_W-1], i_target} - {i_measure[FIELD_W-1], i_measure};
    assign w_diff = {w_err[ERR_W-1], w_err} - {r_prev[ERR_W-1], r_prev};
    assign w_mag  = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);

    // integral update: floor of (err*dt)/2^16, clamp to the bound
    // (err*dt stays below 2^40, so the bits above the slice are sign copies)
    assign w_acc = {{2{r_integ[INTEG_W-1]}}, r_integ}
                 + w_prod[16+DIFF_W-1:16];
    assign w_lim = $signed({3'b000, r_integ_limit});
    always_comb begin
        priority if (w_acc > w_lim) begin
            w_clamped = w_lim[INTEG_W-1:0];
        end else if (w_acc < -w_lim) begin
            w_clamped = INTEG_W'(-w_lim);
        end else begin
            w_clamped = w_acc[INTEG_W-1:0];
        end
    end

    // drive accumulation and final scaling
    assign w_prod_ext = {{(SUM_W-MUL_P_W){w_prod[MUL_P_W-1]}}, w_prod};
    assign w_shr      = r_sum[SUM_W-1:8];
    always_comb begin
        priority if (w_shr > $signed({{(SHR_W-DRIVE_W){1'b0}}, S32_MAX})) begin
            w_drive = S32_MAX;
        end else if (w_shr < $signed({{(SHR_W-DRIVE_W){1'b1}}, S32_MIN})) begin
            w_drive = S32_MIN;
        end else begin
            w_drive = w_shr[DRIVE_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_integ   = r_integ;
        n_prev    = r_prev;
        n_err     = r_err;
        n_sum     = r_sum;
        n_ddone   = r_ddone || w_div_done;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        n_mreq    = r_mreq;
        n_mreq.go = 1'b0;
        n_dreq    = r_dreq;
        n_dreq.go = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_sum = '0;
                    if (i_step_time == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_err      = w_err;
                        n_prev     = w_err;
                        n_ddone    = 1'b0;
                        n_mreq.go  = 1'b1;
                        n_mreq.a   = MUL_A_W'(w_err);
                        n_mreq.b   = i_step_time;
                        n_dreq.go  = 1'b1;
                        n_dreq.num = {w_mag, {DT_W{1'b0}}};
                        n_dreq.den = i_step_time;
                        n_dreq.neg = w_diff[DIFF_W-1];
                        n_state    = S_MI;
                    end
                end
            end
            S_MI: begin
                if (w_mul_done) begin
                    n_integ   = w_clamped;
                    n_mreq.go = 1'b1;
                    n_mreq.a  = MUL_A_W'(r_err);
                    n_mreq.b  = r_gain_prop;
                    n_state   = S_MP;
                end
            end
            S_MP: begin
                if (w_mul_done) begin
                    n_sum     = r_sum + w_prod_ext;
                    n_mreq.go = 1'b1;
                    n_mreq.a  = MUL_A_W'(r_integ);
                    n_mreq.b  = r_gain_integ;
                    n_state   = S_MA;
                end
            end
            S_MA: begin
                if (w_mul_done) begin
                    n_sum   = r_sum + w_prod_ext;
                    n_state = S_WD;
                end
            end
            S_WD: begin
                if (r_ddone) begin
                    n_mreq.go = 1'b1;
                    n_mreq.a  = MUL_A_W'(r_deriv);
                    n_mreq.b  = r_gain_deriv;
                    n_state   = S_MD;
                end
            end
            S_MD: begin
                if (w_mul_done) begin
                    n_sum   = r_sum + w_prod_ext;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out     = w_drive;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_integ   <= '0;
            r_prev    <= '0;
            r_ddone   <= 1'b0;
            r_out_vld <= 1'b0;
            r_mreq    <= '0;
            r_dreq    <= '0;
        end else begin
            r_state   <= n_state;
            r_integ   <= n_integ;
            r_prev    <= n_prev;
            r_ddone   <= n_ddone;
            r_out_vld <= n_out_vld;
            r_mreq    <= n_mreq;
            r_dreq    <= n_dreq;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_err       <= n_err;
        r_sum       <= n_sum;
        r_out       <= n_out;
        if (w_div_done) begin
            r_deriv <= w_quot;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop   <= RST_GAIN_PROP;
            r_gain_integ  <= RST_GAIN_INTEG;
            r_gain_deriv  <= RST_GAIN_DERIV;
            r_integ_limit <= RST_INTEG_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_PROP:   r_gain_prop   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_INTEG:  r_gain_integ  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_DERIV:  r_gain_deriv  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_drive     = r_out;

endmodule

FILE: hw/rtl/pic_checker.sv
// Port-level checks for the PID axis, bound to the top level.
module pic_checker
    import pic_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic        [DT_W-1:0]    i_step_time,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [DRIVE_W-1:0] o_drive
);

    // result word held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive))
        else $error("output word dropped or changed under stall");

    // one word in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a word is in work");

    // zero step time, accepted while the output is free, gives a zero drive on the output
    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_step_time == '0) && !o_out_valid
        |-> ##2 (o_out_valid && (o_drive == '0)))
        else $error("zero step time did not give a zero drive");

    // block takes input right after handing off the zero-step result
    a_zero_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_step_time == '0) && !o_out_valid
        |-> ##2 !o_in_stall)
        else $error("sequencer not idle after zero step");

endmodule

bind pid_integral_clamp pic_checker u_pic_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_step_time (i_step_time),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive     (o_drive)
);

FILE: tb/pid_drive_check.sv
// Drive checker for the PID axis: watches the channels, predicts each drive word and compares.
module pid_drive_check
    import pic_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [FIELD_W-1:0]   i_target,
    input  logic signed [FIELD_W-1:0]   i_measure,
    input  logic        [DT_W-1:0]      i_step_time,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [DRIVE_W-1:0]   i_drive,
    input  logic                        i_cfg_we,
    input  logic        [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [CFG_W-1:0]     i_cfg_data,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_fail_cnt
);

    localparam longint DRIVE_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DRIVE_LO = -64'sh0000_0000_8000_0000;

    // Shadow copy of the gains, bound and loop state
    longint gain_p, gain_i, gain_d, integ_bound;
    longint integ_sum, prev_err_sh;

    // Drive words predicted but not yet seen on the output
    logic signed [DRIVE_W-1:0] pending_drive[$];

    int checked_cnt = 0;
    int fail_cnt    = 0;

    function automatic longint clip32(input longint v);
        if (v > DRIVE_HI)
            return DRIVE_HI;
        if (v < DRIVE_LO)
            return DRIVE_LO;
        return v;
    endfunction

    // One controller step; updates integral and last error unless the step time is zero
    function automatic logic signed [DRIVE_W-1:0] predict_drive(
        input logic signed [FIELD_W-1:0] tgt,
        input logic signed [FIELD_W-1:0] meas,
        input logic        [DT_W-1:0]    dt
    );
        longint err, dt_l, acc, rate, total;
        if (dt == '0)
            return '0;
        dt_l = dt;
        err  = longint'(tgt) - longint'(meas);
        // integral: floor of err*dt/2^16, then clamp to the bound
        acc = integ_sum + ((err * dt_l) >>> 16);
        if (acc > integ_bound)
            acc = integ_bound;
        if (acc < -integ_bound)
            acc = -integ_bound;
        integ_sum = acc;
        // derivative: quotient truncates toward zero
        rate = clip32(((err - prev_err_sh) * 64'sd65536) / dt_l);
        prev_err_sh = err;
        total = gain_p * err + gain_i * acc + gain_d * rate;
        total = clip32(total >>> 8);
        return total[DRIVE_W-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [DRIVE_W-1:0] want;
        if (!i_rst_n) begin
            gain_p      = RST_GAIN_PROP;
            gain_i      = RST_GAIN_INTEG;
            gain_d      = RST_GAIN_DERIV;
            integ_bound = RST_INTEG_LIMIT;
            integ_sum   = 0;
            prev_err_sh = 0;
            pending_drive.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_PROP:   gain_p      = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_INTEG:  gain_i      = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_DERIV:  gain_d      = i_cfg_data[GAIN_W-1:0];
                    CFG_INTEG_LIMIT: integ_bound = i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            // result side first: a word can never come out at its own accept edge
            if (i_out_valid && !i_out_stall) begin
                if (pending_drive.size() == 0) begin
                    $display("%0t: unexpected drive word, expected none, got %0d",
                             $time, i_drive);
                    fail_cnt++;
                end else begin
                    want = pending_drive.pop_front();
                    checked_cnt++;
                    if (want !== i_drive) begin
                        $display("%0t: drive mismatch, expected %0d, got %0d",
                                 $time, want, i_drive);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_drive.push_back(predict_drive(i_target, i_measure, i_step_time));
        end
        o_pending  <= pending_drive.size();
        o_checked  <= checked_cnt;
        o_fail_cnt <= fail_cnt;
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the PID axis: clock, reset, stimulus, output stalls and verdict.
module tb_top
    import pic_pkg::*;
();

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = 24'sh7FFFFF;
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = 24'sh800000;
    localparam logic [DT_W-1:0]           DT_MAX    = 16'hFFFF;
    localparam int                        PHASES    = 6;
    localparam int                        PHASE_LEN = 205;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [FIELD_W-1:0]   target;
    logic signed [FIELD_W-1:0]   measure;
    logic        [DT_W-1:0]      step_time;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [DRIVE_W-1:0]   drive;
    logic                        cfg_we;
    logic        [CFG_IDX_W-1:0] cfg_idx;
    logic        [CFG_W-1:0]     cfg_data;

    int pending, checked, fail_cnt;
    int words_sent    = 0;
    int zero_steps    = 0;
    int settings_used = 1;
    bit calm          = 1'b0;
    bit hold_long     = 1'b0;

    pid_integral_clamp u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_target    (target),
        .i_measure   (measure),
        .i_step_time (step_time),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_drive     (drive),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pid_drive_check u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_target    (target),
        .i_measure   (measure),
        .i_step_time (step_time),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_drive     (drive),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_fail_cnt  (fail_cnt)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one word, with an optional idle burst first; returns at its accept edge
    task automatic send_word(input logic signed [FIELD_W-1:0] tgt,
                             input logic signed [FIELD_W-1:0] meas,
                             input logic        [DT_W-1:0]    dt);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        target    <= tgt;
        measure   <= meas;
        step_time <= dt;
        do @(posedge clk); while (in_stall);
        words_sent++;
        if (dt == '0)
            zero_steps++;
    endtask

    // Drop valid and wait until every predicted word has come out and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (80) @(posedge clk);
    endtask

    // Write all four registers; upper data bits on gain writes are don't-care
    task automatic load_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                 input logic [GAIN_W-1:0] kd, input logic [LIM_W-1:0] lim);
        logic [CFG_W-1:0] junk;
        settle();
        junk     = CFG_W'($urandom);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_GAIN_PROP;
        cfg_data <= {junk[CFG_W-1:GAIN_W], kp};
        @(posedge clk);
        cfg_idx  <= CFG_GAIN_INTEG;
        cfg_data <= {junk[CFG_W-1:GAIN_W], ki};
        @(posedge clk);
        cfg_idx  <= CFG_GAIN_DERIV;
        cfg_data <= {junk[CFG_W-1:GAIN_W], kd};
        @(posedge clk);
        cfg_idx  <= CFG_INTEG_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // Random word: near-tracking errors most often, plus full-range, small and extreme values
    task automatic make_word(output logic signed [FIELD_W-1:0] tgt,
                             output logic signed [FIELD_W-1:0] meas,
                             output logic        [DT_W-1:0]    dt);
        int mode;
        mode = $urandom_range(0, 99);
        tgt  = FIELD_W'($urandom);
        if (mode < 40) begin
            meas = tgt + FIELD_W'($urandom_range(0, 4000)) - 24'sd2000;
        end else if (mode < 70) begin
            meas = FIELD_W'($urandom);
        end else if (mode < 85) begin
            tgt  = FIELD_W'($urandom_range(0, 8191)) - 24'sd4096;
            meas = FIELD_W'($urandom_range(0, 8191)) - 24'sd4096;
        end else begin
            case ($urandom_range(0, 4))
                0: tgt = FIELD_MAX;
                1: tgt = FIELD_MIN;
                2: tgt = '0;
                3: tgt = -24'sd1;
                default: tgt = 24'sd1;
            endcase
            meas = $urandom_range(0, 1) ? FIELD_MAX : FIELD_MIN;
        end
        mode = $urandom_range(0, 99);
        if (mode < 10)
            dt = '0;
        else if (mode < 20)
            dt = 16'd1;
        else if (mode < 25)
            dt = DT_MAX;
        else if (mode < 45)
            dt = DT_W'($urandom_range(1, 64));
        else
            dt = DT_W'($urandom_range(1, 65535));
    endtask

    // Output side: short random stalls, one long hold-off on request, none when calm
    initial begin
        out_stall <= 1'b0;
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Stimulus
    initial begin
        logic signed [FIELD_W-1:0] tgt, meas;
        logic        [DT_W-1:0]    dt;
        logic        [GAIN_W-1:0]  kp, ki, kd;
        logic        [LIM_W-1:0]   lim;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        target    <= '0;
        measure   <= '0;
        step_time <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_GAIN_PROP;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: field extremes, zero and full-scale step times, saturating derivative
        send_word('0, '0, 16'd1);
        send_word(FIELD_MAX, FIELD_MIN, DT_MAX);
        send_word(FIELD_MIN, FIELD_MAX, 16'd1);
        send_word(FIELD_MAX, FIELD_MIN, 16'd1);
        send_word(24'sd100, -24'sd100, '0);
        send_word(24'sd123456, '0, '0);
        send_word(24'sd1000, 24'sd200, 16'd300);
        send_word(-24'sd5000, 24'sd7000, DT_MAX);
        send_word('0, '0, DT_MAX);
        send_word(FIELD_MAX, FIELD_MIN, 16'd1000);

        // bound lowered below the held integral: clamps only on the next real step
        load_settings(RST_GAIN_PROP, RST_GAIN_INTEG, RST_GAIN_DERIV, 23'd100);
        send_word('0, '0, 16'd100);
        send_word(-24'sd1, '0, 16'd1);
        send_word(24'sd1, '0, 16'd2);

        // all gains and the bound at full scale
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 23'h7FFFFF);
        send_word(FIELD_MAX, FIELD_MIN, DT_MAX);
        send_word(FIELD_MAX, FIELD_MIN, 16'd1);
        send_word(FIELD_MIN, FIELD_MAX, 16'd1);
        send_word(FIELD_MIN, FIELD_MAX, DT_MAX);
        send_word(24'sd1, -24'sd1, '0);

        // everything zero
        load_settings('0, '0, '0, '0);
        send_word(FIELD_MIN, FIELD_MAX, 16'd5);
        send_word(FIELD_MAX, FIELD_MIN, 16'd7);
        send_word('0, '0, '0);

        // random phases, one register setting each
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    kp = GAIN_W'($urandom_range(0, 1023));
                    ki = GAIN_W'($urandom_range(0, 1023));
                    kd = GAIN_W'($urandom_range(0, 1023));
                    lim = LIM_W'($urandom_range(0, 200000));
                end
                1: begin
                    kp = GAIN_W'($urandom);
                    ki = GAIN_W'($urandom);
                    kd = GAIN_W'($urandom);
                    lim = LIM_W'($urandom);
                end
                2: begin
                    kp = 16'hFFFF;
                    ki = 16'hFFFF;
                    kd = 16'hFFFF;
                    lim = 23'h7FFFFF;
                end
                3: begin
                    kp = '0;
                    ki = 16'hFFFF;
                    kd = '0;
                    lim = LIM_W'($urandom_range(0, 5000));
                end
                4: begin
                    kp = GAIN_W'($urandom);
                    ki = GAIN_W'($urandom);
                    kd = GAIN_W'($urandom);
                    lim = '0;
                end
                default: begin
                    kp = GAIN_W'($urandom_range(0, 2047));
                    ki = GAIN_W'($urandom_range(0, 2047));
                    kd = GAIN_W'($urandom_range(0, 2047));
                    lim = LIM_W'($urandom);
                end
            endcase
            load_settings(kp, ki, kd, lim);
            if (ph == 1)
                hold_long = 1'b1;
            if (ph == PHASES - 1)
                calm = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++) begin
                make_word(tgt, meas, dt);
                send_word(tgt, meas, dt);
            end
        end

        settle();
        $display("Covered %0d words (%0d with zero step time) across %0d register settings,",
                 words_sent, zero_steps, settings_used);
        $display("with output hold-off and random idle on both channels; %0d drive words compared.",
                 checked);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
